// File: rtl/assert_macros.svh
// Assertion macros, included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, live through reset as well
`define ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

// File: rtl/ps2qm_pkg.sv
// Package: constants, types and the step remap for the PS/2 quadrature mouse
`default_nettype none
package ps2qm_pkg;

  localparam int CNT_W     = 16;   // pending step counter width (4..32)
  localparam int MAXMOV_W  = 16;   // max_movement register width
  localparam int CMP_W     = ((CNT_W > MAXMOV_W) ? CNT_W : MAXMOV_W) + 1;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_MOVEMENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AMIGA_MODE   = CFG_IDX_W'(1);

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [MAXMOV_W-1:0] MAX_MOVEMENT_RST = MAXMOV_W'(255);
  localparam logic [1:0]          PHASE_RST        = 2'd1;
  localparam logic [2:0]          STEP_CAP         = 3'd7;

  typedef struct packed {
    logic commit;   // word moves from input register to result register
    logic tick;     // word is an output tick
    logic amiga;    // keep raw magnitude
  } axis_ctl_t;

  // Magnitude to step count: optional halving, coarse remap, cap at 7
  function automatic logic [2:0] remap_steps(input logic [7:0] mag_in, input logic amiga);
    logic [7:0] mag;
    logic [6:0] half;
    logic [2:0] steps;
    mag  = amiga ? mag_in : {1'b0, mag_in[7:1]};
    half = mag[7:1];
    if (mag <= 8'd2)       steps = 3'd1;
    else if (mag == 8'd3)  steps = 3'd3;
    else if (mag <= 8'd6)  steps = 3'd4;
    else if (mag <= 8'd9)  steps = 3'd5;
    else if (half > 7'(STEP_CAP)) steps = STEP_CAP;
    else                   steps = half[2:0];
    return steps;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ps2qm_axis.sv
// One quadrature axis: pending step count, direction and phase
`default_nettype none
module ps2qm_axis
  import ps2qm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire axis_ctl_t        ctl,
  input  wire logic [7:0]       delta,
  input  wire logic             neg,
  input  wire logic [CNT_W-1:0] limit,
  output logic                  pending_nz,
  output logic [1:0]            phase,
  output logic [1:0]            phase_nxt
);

  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic             backward_r, backward_nxt;
  logic [1:0]       phase_r;

  logic [7:0]       mag;
  logic [2:0]       steps;
  logic [CNT_W:0]   base;

  assign pending_nz = (pending_r != '0);
  assign phase      = phase_r;

  // two's-complement magnitude when the sign flag is set
  assign mag   = neg ? (~delta + 8'd1) : delta;
  assign steps = remap_steps(mag, ctl.amiga);

  always_comb begin
    pending_nxt  = pending_r;
    backward_nxt = backward_r;
    phase_nxt    = phase_r;
    base         = {1'b0, pending_r};
    if (ctl.tick) begin
      if (pending_nz) begin
        phase_nxt   = backward_r ? (phase_r - 2'd1) : (phase_r + 2'd1);
        pending_nxt = pending_r - CNT_W'(1);
      end
    end else begin
      if (delta != 8'd0) begin
        if (backward_r == neg) begin
          base = {1'b0, pending_r} + (CNT_W+1)'(steps);
        end else begin
          base         = '0;
          backward_nxt = neg;
        end
      end
      pending_nxt = (base > {1'b0, limit}) ? limit : base[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      backward_r <= 1'b0;
      phase_r    <= PHASE_RST;
    end else if (ctl.commit) begin
      pending_r  <= pending_nxt;
      backward_r <= backward_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ps2_to_quadrature_mouse.sv
// Top level: PS/2 mouse packets to Amiga/Atari quadrature and button pins
//
//   channel  dir   handshake            payload
//   in_      in    in_valid / in_stall  in_mode, in_flags, in_x_delta, in_y_delta
//   out_     out   out_valid / out_stall pins x_a..y_b, buttons, LEDs
//   cfg_     in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; each word passes the input
// register, then the result register. The state update sits between them.
// Synchronous active-low reset: counts zero, phases 1, buttons released.
// A stalled result holds; the input register keeps taking words while the
// result register is free or being drained, so in_stall follows out_stall.
`default_nettype none
`include "assert_macros.svh"
module ps2_to_quadrature_mouse
  import ps2qm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [7:0]           in_flags,
  input  wire logic [7:0]           in_x_delta,
  input  wire logic [7:0]           in_y_delta,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_x_a,
  output logic                      out_x_b,
  output logic                      out_y_a,
  output logic                      out_y_b,
  output logic                      out_left_pin,
  output logic                      out_middle_pin,
  output logic                      out_right_pin,
  output logic                      out_button_led,
  output logic                      out_x_led,
  output logic                      out_y_led,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  // configuration
  logic [MAXMOV_W-1:0] max_movement_r;
  logic                amiga_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_movement_r <= MAX_MOVEMENT_RST;
      amiga_mode_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_MOVEMENT: max_movement_r <= cfg_data[MAXMOV_W-1:0];
        REG_AMIGA_MODE:   amiga_mode_r   <= cfg_data[0];
        default:          ;  // unmapped index, ignored
      endcase
    end
  end

  // limit = min(max_movement, counter full scale)
  logic [CMP_W-1:0] max_ext, full_ext;
  logic [CNT_W-1:0] limit;

  assign max_ext  = CMP_W'(max_movement_r);
  assign full_ext = CMP_W'({CNT_W{1'b1}});
  assign limit    = (max_ext > full_ext) ? {CNT_W{1'b1}} : CNT_W'(max_ext);

  // input register
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_flags_r, s1_xd_r, s1_yd_r;
  logic       adv, commit, take;

  assign adv      = !out_valid || !out_stall;   // result register free next edge
  assign commit   = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (commit) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_mode_r  <= in_mode;
      s1_flags_r <= in_flags;
      s1_xd_r    <= in_x_delta;
      s1_yd_r    <= in_y_delta;
    end
  end

  // axes
  axis_ctl_t  ctl;
  logic       x_nz, y_nz;
  logic [1:0] x_phase, y_phase, x_phase_nxt, y_phase_nxt;

  assign ctl = '{commit: commit, tick: (s1_mode_r == MODE_TICK), amiga: amiga_mode_r};

  ps2qm_axis u_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .delta      (s1_xd_r),
    .neg        (s1_flags_r[4]),
    .limit      (limit),
    .pending_nz (x_nz),
    .phase      (x_phase),
    .phase_nxt  (x_phase_nxt)
  );

  ps2qm_axis u_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .delta      (s1_yd_r),
    .neg        (s1_flags_r[5]),
    .limit      (limit),
    .pending_nz (y_nz),
    .phase      (y_phase),
    .phase_nxt  (y_phase_nxt)
  );

  // buttons: latch holds pressed bits {right, middle, left}
  logic [2:0] btn_latch_r, btn_latch_nxt;
  logic [2:0] btn_drive_r, btn_drive_nxt;
  logic [2:0] led_r, led_nxt;

  always_comb begin
    btn_latch_nxt = btn_latch_r;
    btn_drive_nxt = btn_drive_r;
    led_nxt       = led_r;
    if (ctl.tick) begin
      btn_drive_nxt = ~btn_latch_r;
      led_nxt       = {y_nz, x_nz, (btn_latch_r != 3'b000)};  // LEDs see counts before the step
    end else begin
      btn_latch_nxt = {s1_flags_r[1], s1_flags_r[2], s1_flags_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_latch_r <= 3'b000;
      btn_drive_r <= 3'b111;
      led_r       <= 3'b000;
    end else if (commit) begin
      btn_latch_r <= btn_latch_nxt;
      btn_drive_r <= btn_drive_nxt;
      led_r       <= led_nxt;
    end
  end

  // result register; quadrature pins are the Gray code of the phase
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      out_x_a        <= !x_phase_nxt[1];
      out_x_b        <= x_phase_nxt[1] ^ x_phase_nxt[0];
      out_y_a        <= !y_phase_nxt[1];
      out_y_b        <= y_phase_nxt[1] ^ y_phase_nxt[0];
      out_left_pin   <= btn_drive_nxt[0];
      out_middle_pin <= btn_drive_nxt[1];
      out_right_pin  <= btn_drive_nxt[2];
      out_button_led <= led_nxt[0];
      out_x_led      <= led_nxt[1];
      out_y_led      <= led_nxt[2];
    end
  end

  // checks
  logic tick_commit;

  assign tick_commit = commit && ctl.tick;

  `ASSERT_RST(a_s1_held, clk, rst_n, in_stall |=> s1_valid_r, "waiting word dropped")
  `ASSERT_RST(a_x_idle, clk, rst_n, (tick_commit && !x_nz) |=> $stable(x_phase), "x phase moved")
  `ASSERT_RST(a_y_idle, clk, rst_n, (tick_commit && !y_nz) |=> $stable(y_phase), "y phase moved")
  `ASSERT_RST(a_btn_tick, clk, rst_n, !tick_commit |=> $stable(btn_drive_r), "buttons moved")
  `ASSERT_ALL(a_rst_idle, clk, !rst_n |=> (!out_valid && !s1_valid_r), "valid after reset")

endmodule
`default_nettype wire
